/* src/per_host_byte_accounting_top_macros.svh */
// Assertion macros for the per-host byte accounting checker
`ifndef PER_HOST_BYTE_ACCOUNTING_TOP_MACROS_SVH
`define PER_HOST_BYTE_ACCOUNTING_TOP_MACROS_SVH
// clocked assertion, muted while in reset
`define PHBA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("phba assertion failed");
`endif

/* src/phba_pkg.sv */
// Package: types and constants for the per-host byte accounting block
`default_nettype none
package phba_pkg;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] MIN_WIRE_LEN   = 16'd34;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam int          CFG_IDX_W      = 2;
	localparam int          CNT_W          = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_MAC, REG_MIN_HDR_WORDS, REG_MIN_FRAME_LEN, REG_MAX_FRAME_LEN
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_DROPPED, ST_NOT_LOCAL, ST_UPDATED, ST_INSERTED, ST_TABLE_FULL
	} status_t;

	typedef enum logic [1:0] {KIND_DROP, KIND_OTHER, KIND_LOCAL} kind_t;

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CMP, S_UPD} state_t;

	typedef struct packed {
		logic [15:0] captured_length;
		logic [15:0] wire_length;
		logic [15:0] frame_type;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [3:0]  ip_version;
		logic [3:0]  header_words;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
	} item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      host_ip;
		logic             outbound;
		logic [CNT_W-1:0] host_bytes_in;
		logic [CNT_W-1:0] host_bytes_out;
		logic [CNT_W-1:0] host_bytes_all;
	} result_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] host;
		logic        outbound;
		logic [15:0] wire_len;
	} qitem_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [15:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-15){1'b0}}, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction
endpackage
`default_nettype wire

/* src/phba_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module phba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end
	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/phba_front.sv */
// Front end: config registers, frame validation, two-entry queue to the back end
`default_nettype none
module phba_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire phba_pkg::item_t                     item,
	output      logic                                busy,
	input  wire logic                                cfg_wr,
	input  wire logic [phba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [47:0]                         cfg_data,
	output      logic                                q_valid,
	output      phba_pkg::qitem_t                    q_item,
	input  wire logic                                q_pop
);
	logic [47:0] local_mac_q;
	logic [3:0]  min_hw_q;
	logic [15:0] min_len_q, max_len_q;
	phba_pkg::qitem_t fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, valid_frame;
	phba_pkg::qitem_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q <= '0;
			min_hw_q    <= 4'd5;
			min_len_q   <= 16'd64;
			max_len_q   <= 16'd1518;
		end else if (cfg_wr) begin
			case (phba_pkg::reg_idx_t'(cfg_index))
				phba_pkg::REG_LOCAL_MAC:     local_mac_q <= cfg_data;
				phba_pkg::REG_MIN_HDR_WORDS: min_hw_q    <= cfg_data[3:0];
				phba_pkg::REG_MIN_FRAME_LEN: min_len_q   <= cfg_data[15:0];
				phba_pkg::REG_MAX_FRAME_LEN: max_len_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		valid_frame = (item.captured_length >= min_len_q) &&
			(item.captured_length <= max_len_q) &&
			(item.frame_type == phba_pkg::ETHERTYPE_IPV4) &&
			(item.wire_length >= phba_pkg::MIN_WIRE_LEN) &&
			(item.ip_version == phba_pkg::IP_VERSION_4) &&
			(item.header_words >= min_hw_q);
		cls.wire_len = item.wire_length;
		cls.host     = '0;
		cls.outbound = 1'b0;
		if (!valid_frame) begin
			cls.kind = phba_pkg::KIND_DROP;
		end else if (item.dest_mac == local_mac_q) begin
			cls.kind = phba_pkg::KIND_LOCAL;
			cls.host = item.dest_ip;
		end else if (item.source_mac == local_mac_q) begin
			cls.kind     = phba_pkg::KIND_LOCAL;
			cls.host     = item.source_ip;
			cls.outbound = 1'b1;
		end else begin
			cls.kind = phba_pkg::KIND_OTHER;
		end
	end

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

/* src/phba_back.sv */
// Back end: linear table search, counter update or insert, result register
`default_nettype none
module phba_back #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire phba_pkg::qitem_t     q_item,
	output      logic                 q_pop,
	output      logic                 done,
	output      phba_pkg::result_t    result
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TW = 3 * phba_pkg::CNT_W;

	phba_pkg::state_t  state_q, state_d;
	phba_pkg::qitem_t  cur_q;
	logic [CW-1:0]     idx_q, used_q;
	logic              done_q;
	phba_pkg::result_t result_q, res_d;
	logic              emit, idx_inc, idx_clr, used_inc;
	logic              a_we, a_re, c_we, c_re;
	logic [AW-1:0]     c_waddr;
	logic [TW-1:0]     c_wdata, c_rdata;
	logic [31:0]       a_rdata;
	logic [phba_pkg::CNT_W-1:0] add_in, add_out, add_all, rd_in, rd_out, rd_all;
	logic [phba_pkg::CNT_W-1:0] nw_in, nw_out, nw_all;
	logic              at_end, full;

	phba_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr_ram (
		.clk(clk), .we(a_we), .waddr(used_q[AW-1:0]), .wdata(cur_q.host),
		.re(a_re), .raddr(idx_q[AW-1:0]), .rdata(a_rdata));

	phba_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.re(c_re), .raddr(idx_q[AW-1:0]), .rdata(c_rdata));

	assign add_in  = cur_q.outbound ? '0 : {{(phba_pkg::CNT_W-16){1'b0}}, cur_q.wire_len};
	assign add_out = cur_q.outbound ? {{(phba_pkg::CNT_W-16){1'b0}}, cur_q.wire_len} : '0;
	assign add_all = {{(phba_pkg::CNT_W-16){1'b0}}, cur_q.wire_len};
	assign {rd_in, rd_out, rd_all} = c_rdata;
	assign nw_in  = phba_pkg::sat_add(rd_in, cur_q.outbound ? 16'd0 : cur_q.wire_len);
	assign nw_out = phba_pkg::sat_add(rd_out, cur_q.outbound ? cur_q.wire_len : 16'd0);
	assign nw_all = phba_pkg::sat_add(rd_all, cur_q.wire_len);
	assign at_end = (idx_q == used_q);
	assign full   = (used_q == CW'(TABLE_DEPTH));

	always_comb begin
		state_d = state_q;
		case (state_q)
			phba_pkg::S_IDLE: if (q_valid) state_d = phba_pkg::S_LOOK;
			phba_pkg::S_LOOK: begin
				if (cur_q.kind != phba_pkg::KIND_LOCAL || at_end) state_d = phba_pkg::S_IDLE;
				else state_d = phba_pkg::S_CMP;
			end
			phba_pkg::S_CMP: begin
				if (a_rdata == cur_q.host) state_d = phba_pkg::S_UPD;
				else state_d = phba_pkg::S_LOOK;
			end
			phba_pkg::S_UPD: state_d = phba_pkg::S_IDLE;
			default: state_d = phba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		emit     = 1'b0;
		idx_inc  = 1'b0;
		idx_clr  = 1'b0;
		used_inc = 1'b0;
		a_we     = 1'b0;
		a_re     = 1'b0;
		c_we     = 1'b0;
		c_re     = 1'b0;
		c_waddr  = idx_q[AW-1:0];
		c_wdata  = {nw_in, nw_out, nw_all};
		res_d    = '0;
		case (state_q)
			phba_pkg::S_IDLE: begin
				q_pop   = q_valid;
				idx_clr = 1'b1;
			end
			phba_pkg::S_LOOK: begin
				if (cur_q.kind == phba_pkg::KIND_DROP) begin
					emit         = 1'b1;
					res_d.status = phba_pkg::ST_DROPPED;
				end else if (cur_q.kind == phba_pkg::KIND_OTHER) begin
					emit         = 1'b1;
					res_d.status = phba_pkg::ST_NOT_LOCAL;
				end else if (at_end) begin
					emit           = 1'b1;
					res_d.host_ip  = cur_q.host;
					res_d.outbound = cur_q.outbound;
					if (full) begin
						res_d.status = phba_pkg::ST_TABLE_FULL;
					end else begin
						res_d.status         = phba_pkg::ST_INSERTED;
						res_d.host_bytes_in  = add_in;
						res_d.host_bytes_out = add_out;
						res_d.host_bytes_all = add_all;
						a_we     = 1'b1;
						c_we     = 1'b1;
						c_waddr  = used_q[AW-1:0];
						c_wdata  = {add_in, add_out, add_all};
						used_inc = 1'b1;
					end
				end else begin
					a_re = 1'b1;
				end
			end
			phba_pkg::S_CMP: begin
				if (a_rdata == cur_q.host) c_re = 1'b1;
				else idx_inc = 1'b1;
			end
			phba_pkg::S_UPD: begin
				emit                 = 1'b1;
				c_we                 = 1'b1;
				res_d.status         = phba_pkg::ST_UPDATED;
				res_d.host_ip        = cur_q.host;
				res_d.outbound       = cur_q.outbound;
				res_d.host_bytes_in  = nw_in;
				res_d.host_bytes_out = nw_out;
				res_d.host_bytes_all = nw_all;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (emit) result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phba_pkg::S_IDLE;
			idx_q   <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (idx_clr) idx_q <= '0;
			else if (idx_inc) idx_q <= idx_q + CW'(1);
			if (used_inc) used_q <= used_q + CW'(1);
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule
`default_nettype wire

/* src/per_host_byte_accounting_top.sv */
// Top level of the per-host byte accounting block
// Results cannot be stalled: each shows on result for one cycle with done high.
// A dropped or non-local frame is reported from the back end's look state. A
// local frame is searched linearly over the address RAM, through the look and
// compare states for each entry up to and including the hit, then the update
// state; with no hit the look state inserts it or reports the table full. A
// two-entry queue lets start be taken while the back end is searching.
`default_nettype none
module per_host_byte_accounting_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire phba_pkg::item_t                item,
	output      logic                           busy,
	output      logic                           done,
	output      phba_pkg::result_t              result,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [phba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]                    cfg_data
);
	logic             q_valid, q_pop;
	phba_pkg::qitem_t q_item;

	assign cfg_ready = 1'b1;

	phba_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

	phba_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .done(done), .result(result));
endmodule
`default_nettype wire

/* src/phba_checker.sv */
// Port-level checker for the per-host byte accounting block, with bind
`default_nettype none
`include "per_host_byte_accounting_top_macros.svh"
module phba_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              done,
	input wire phba_pkg::result_t result
);
	logic quiet_word, quiet_ok, full_word, full_ok;

	assign quiet_word = done && (result.status == phba_pkg::ST_DROPPED ||
		result.status == phba_pkg::ST_NOT_LOCAL);
	assign quiet_ok   = (result.host_ip == '0) && !result.outbound &&
		(result.host_bytes_all == '0);
	assign full_word  = done && (result.status == phba_pkg::ST_TABLE_FULL);
	assign full_ok    = (result.host_bytes_in == '0) && (result.host_bytes_out == '0) &&
		(result.host_bytes_all == '0);

	`PHBA_ASSERT(a_status_range, done |-> (result.status <= phba_pkg::ST_TABLE_FULL))
	`PHBA_ASSERT(a_drop_zero, quiet_word |-> quiet_ok)
	`PHBA_ASSERT(a_full_zero, full_word |-> full_ok)
	`PHBA_ASSERT(a_done_pulse, done |=> !done)
endmodule

bind per_host_byte_accounting_top phba_checker u_phba_checker (
	.clk(clk), .arst_n(arst_n), .done(done), .result(result));
`default_nettype wire
